### rtl/core/paged_memory_address_mapper_assert.svh
// assertion macros for the paged memory address mapper
// used by the top level; expects clk and rst_n in scope at the point of use
`ifndef PAGED_MEMORY_ADDRESS_MAPPER_ASSERT_SVH
`define PAGED_MEMORY_ADDRESS_MAPPER_ASSERT_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define PMAM_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pmam same-cycle check failed");

// antecedent implies consequent in the next cycle
`define PMAM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pmam next-cycle check failed");

`else

`define PMAM_ASSERT_SAME(label, ante, cons)
`define PMAM_ASSERT_NEXT(label, ante, cons)

`endif

`endif

### rtl/core/pmam_pkg.sv
// shared types and constants for the paged memory address mapper
// no dependencies; imported by pmam_xlate and the top level
package pmam_pkg;

    localparam int ADDR_W      = 16;
    localparam int PHYS_W      = 20;
    localparam int DATA_W      = 8;
    localparam int SIZE_W      = 5;
    localparam int UNIT_SHIFT  = 15;   // 32 KB ram units
    localparam int PAGE_NUM_W  = 7;    // physical 8 KB page number
    localparam int OFFSET_W    = 13;   // offset within an 8 KB window

    localparam logic [SIZE_W-1:0] RAM_SIZE_RESET = 5'd2;

    typedef enum logic [1:0] {
        REQ_PAGE  = 2'd0,
        REQ_READ  = 2'd1,
        REQ_WRITE = 2'd2
    } req_t;

    typedef struct packed {
        logic       all_ram;
        logic [2:0] rom_page;
        logic [3:0] ram_page;
    } page_cfg_t;

endpackage

### rtl/core/pmam_xlate.sv
// logical to physical address translation for the paged mapper
// depends on pmam_pkg (page_cfg_t, widths)
module pmam_xlate (
    input  logic [15:0]           cpu_address,
    input  pmam_pkg::page_cfg_t   page_cfg,
    output logic                  is_ram,
    output logic [19:0]           phys_address
);
    import pmam_pkg::*;

    logic [2:0]            win;
    logic [2:0]            top_page;
    logic [OFFSET_W-1:0]   off;
    logic [PAGE_NUM_W-1:0] page_num;
    logic [PAGE_NUM_W-1:0] rp_x6;
    logic [PAGE_NUM_W-1:0] rp_x4;
    logic [3:0]            rom_sel;

    always_comb
    begin
        win      = cpu_address[15:13];
        off      = cpu_address[OFFSET_W-1:0];
        top_page = ~win;
        // ram page step in 8 KB units: 6 in all-ram mode, 4 in rom mode
        rp_x4    = {1'b0, page_cfg.ram_page, 2'b00};
        rp_x6    = rp_x4 + {2'b00, page_cfg.ram_page, 1'b0};
        rom_sel  = {1'b0, page_cfg.rom_page} + 4'd1;

        is_ram = page_cfg.all_ram || (cpu_address[15:14] != 2'b00);

        if (cpu_address[15:14] == 2'b11)
        begin
            page_num = {4'b0000, top_page};
        end
        else if (page_cfg.all_ram)
        begin
            page_num = {4'b0000, top_page} + rp_x6;
        end
        else if (win == 3'd0)
        begin
            page_num = '0;
        end
        else if (win == 3'd1)
        begin
            page_num = {3'b000, rom_sel};
        end
        else
        begin
            page_num = {4'b0000, top_page} + rp_x4;
        end

        phys_address = {page_num, off};
    end

endmodule

### rtl/core/paged_memory_address_mapper.sv
// paged memory address mapper: page register plus cpu address translation
// depends on pmam_pkg, pmam_xlate and paged_memory_address_mapper_assert.svh
// 2 register stages, input then result: an accepted word moves on to the result register once that is free
// throughput one word per cycle while out_stall is low; a page write takes effect for the very next word
// async active-low reset: pipeline empty, ram size 2 units, rom mode, both pages 0
`include "paged_memory_address_mapper_assert.svh"

module paged_memory_address_mapper (
    input  logic        clk,
    input  logic        rst_n,

    // configuration: installed ram size in 32 KB units
    input  logic        cfg_wr_en,
    input  logic [4:0]  cfg_wr_data,

    // request channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [15:0] cpu_address,
    input  logic [7:0]  write_data,

    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic        is_ram,
    output logic [19:0] phys_address,
    output logic        access_ok,
    output logic [7:0]  mem_wdata
);
    import pmam_pkg::*;

    // ram size register
    logic [SIZE_W-1:0]  ram_size_reg;

    // page register state
    page_cfg_t          page_reg;
    page_cfg_t          page_next;

    // input stage
    logic               s1_valid_reg;
    logic [1:0]         s1_req_reg;
    logic [ADDR_W-1:0]  s1_addr_reg;
    logic [DATA_W-1:0]  s1_data_reg;

    // result stage
    logic               out_valid_reg;
    logic               is_ram_reg;
    logic [PHYS_W-1:0]  phys_reg;
    logic               ok_reg;
    logic [DATA_W-1:0]  wdata_reg;

    logic               is_ram_next;
    logic [PHYS_W-1:0]  phys_next;
    logic               ok_next;
    logic [DATA_W-1:0]  wdata_next;

    // translation outputs
    logic               xl_is_ram;
    logic [PHYS_W-1:0]  xl_phys;
    logic [PHYS_W-1:0]  ram_limit;

    // handshake
    logic               out_adv;
    logic               s1_move;
    logic               in_take;
    logic               s1_page_move;

    // result register frees when empty or being taken
    assign out_adv  = !out_valid_reg || !out_stall;
    assign s1_move  = s1_valid_reg && out_adv;
    // input register frees when empty or moving forward this cycle
    assign in_stall = s1_valid_reg && !out_adv;
    assign in_take  = in_valid && !in_stall;
    // a page write leaving the input stage
    assign s1_page_move = s1_move && (s1_req_reg == REQ_PAGE);

    // translate against the page state current for the word in the input stage
    pmam_xlate u_xlate (
        .cpu_address  (s1_addr_reg),
        .page_cfg     (page_reg),
        .is_ram       (xl_is_ram),
        .phys_address (xl_phys)
    );

    // ram present below ram_size * 32 KB
    assign ram_limit = {ram_size_reg, {UNIT_SHIFT{1'b0}}};

    always_comb
    begin
        page_next   = page_reg;
        is_ram_next = 1'b0;
        phys_next   = '0;
        ok_next     = 1'b0;
        wdata_next  = '0;

        case (s1_req_reg)
            REQ_PAGE:
            begin
                page_next.all_ram  = s1_data_reg[7];
                page_next.rom_page = s1_data_reg[6:4];
                page_next.ram_page = s1_data_reg[3:0];
                ok_next            = 1'b1;
            end
            REQ_READ, REQ_WRITE:
            begin
                is_ram_next = xl_is_ram;
                phys_next   = xl_phys;
                if (xl_is_ram)
                begin
                    ok_next = (xl_phys < ram_limit);
                end
                else
                begin
                    // rom reads always go, rom writes are refused
                    ok_next = (s1_req_reg == REQ_READ);
                end
                if ((s1_req_reg == REQ_WRITE) && ok_next)
                begin
                    wdata_next = s1_data_reg;
                end
            end
            default:
            begin
                // unused request code: all-zero result, no state change
                ok_next = 1'b0;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ram_size_reg  <= RAM_SIZE_RESET;
            page_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                ram_size_reg <= cfg_wr_data;
            end
            if (s1_move)
            begin
                page_reg <= page_next;
            end
            if (in_take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (out_adv)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_req_reg  <= req_type;
            s1_addr_reg <= cpu_address;
            s1_data_reg <= write_data;
        end
        if (s1_move)
        begin
            is_ram_reg <= is_ram_next;
            phys_reg   <= phys_next;
            ok_reg     <= ok_next;
            wdata_reg  <= wdata_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign is_ram       = is_ram_reg;
    assign phys_address = phys_reg;
    assign access_ok    = ok_reg;
    assign mem_wdata    = wdata_reg;

    // checks

    // the input side only stalls while the input stage holds a word
    `PMAM_ASSERT_SAME(a_stall_needs_s1, in_stall, s1_valid_reg)

    // a nonzero store byte only leaves with a granted access
    `PMAM_ASSERT_SAME(a_wdata_needs_ok, out_valid_reg && (mem_wdata != 8'd0), access_ok)

    // a page write that moves forward loads the page register from its data word
    `PMAM_ASSERT_NEXT(a_page_load, s1_page_move, page_reg == $past(s1_data_reg))

endmodule
